FILE: sv/fbpa_pkg.sv
package fbpa_pkg;

   localparam int KIND_W       = 2;
   localparam int STATUS_W     = 3;
   localparam int REQ_INDEX_W  = 10;
   localparam int USE_W        = 11;
   localparam int COUNT_W      = 32;
   localparam int STRIDE_W     = 17;
   localparam int BASE_W       = 32;
   localparam int BLK_COUNT_W  = 11;
   localparam int BLK_BYTES_W  = 16;
   localparam int ALIGN_W      = 4;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int REQ_TDATA_W  = 16;
   localparam int REQ_TUSER_W  = 2;
   localparam int RSP_TDATA_W  = 176;
   localparam int RSP_TUSER_W  = 3;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REINIT = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_EXHAUSTED   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NULL_FREE   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_BAD_INDEX   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NONE_IN_USE = 3'd4;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_BLOCK_COUNT  = 2'd1;
   localparam logic [1:0] CSR_BLOCK_BYTES  = 2'd2;
   localparam logic [1:0] CSR_ALIGN_LOG2   = 2'd3;

   localparam logic [USE_W-1:0]   USE_MAX   = 11'd2047;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic mul;
      logic load;
   } cmd_type;

endpackage

FILE: sv/fbpa_ctrl.sv
module fbpa_ctrl
   import fbpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_MUL;
         ST_MUL:  state_in = ST_FIN;
         ST_FIN: begin
            // leave only once the output register can take the result
            if (!out_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_EXEC: cmd.exec = 1'b1;
         ST_MUL:  cmd.mul  = 1'b1;
         ST_FIN:  cmd.load = !out_valid_ff || rsp_tready;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   a_accept_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> cmd.exec)
      else $error("accepted request not executed next cycle");

   a_exec_then_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> cmd.mul)
      else $error("execute not followed by multiply");

   a_load_shows_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_tvalid)
      else $error("loaded result not presented");

endmodule

FILE: sv/fbpa_datapath.sv
module fbpa_datapath
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS    = 1024,
   parameter int ADDR_BITS     = 32,
   parameter int POINTER_BYTES = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic                   req_block_present,
   input  logic [REQ_INDEX_W-1:0] req_block_index,
   input  logic [BASE_W-1:0]      cfg_base_address,
   input  logic [BLK_COUNT_W-1:0] cfg_block_count,
   input  logic [BLK_BYTES_W-1:0] cfg_block_bytes,
   input  logic [ALIGN_W-1:0]     cfg_align_log2,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [REQ_INDEX_W-1:0] rsp_granted_index,
   output logic [31:0]            rsp_granted_address,
   output logic [31:0]            rsp_used_bytes,
   output logic [31:0]            rsp_peak_bytes,
   output logic [COUNT_W-1:0]     rsp_alloc_total,
   output logic [COUNT_W-1:0]     rsp_fail_total
);

   localparam int IW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int HW   = $clog2(MAX_BLOCKS + 1);
   localparam int CNTW = (HW > BLK_COUNT_W) ? HW : BLK_COUNT_W;
   localparam int AW   = (ADDR_BITS < 32) ? ADDR_BITS : 32;
   localparam logic [31:0]         ADDR_MASK = 32'((64'd1 << AW) - 64'd1);
   localparam logic [HW-1:0]       EMPTY     = HW'(MAX_BLOCKS);
   localparam logic [CNTW-1:0]     CNT_LIMIT = CNTW'(MAX_BLOCKS);
   localparam logic [STRIDE_W-1:0] PTR_BYTES = STRIDE_W'(POINTER_BYTES);

   logic [HW-1:0] link_mem [MAX_BLOCKS];
   logic [HW-1:0] link_rd_ff;

   logic [KIND_W-1:0]      kind_ff;
   logic                   present_ff;
   logic [REQ_INDEX_W-1:0] index_ff;

   logic [HW-1:0]      head_ff, head_in;
   logic [CNTW-1:0]    fresh_ff, fresh_in;
   logic [USE_W-1:0]   in_use_ff, in_use_in;
   logic [USE_W-1:0]   peak_ff, peak_in;
   logic [COUNT_W-1:0] alloc_ff, alloc_in;
   logic [COUNT_W-1:0] fail_ff, fail_in;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic                grant_ff, grant_in;
   logic [IW-1:0]       gidx_ff, gidx_in;
   logic                link_we;

   logic [CNTW-1:0]     count_now;
   logic [USE_W-1:0]    use_inc;
   logic [STRIDE_W-1:0] align_m1;
   logic [STRIDE_W-1:0] rounded;
   logic [STRIDE_W-1:0] stride;

   logic [IW+STRIDE_W-1:0]    addr_prod;
   logic [31:0]               addr_prod_ff;
   logic [USE_W+STRIDE_W-1:0] used_prod_ff;
   logic [USE_W+STRIDE_W-1:0] peak_prod_ff;

   assign count_now = (CNTW'(cfg_block_count) > CNT_LIMIT) ? CNT_LIMIT
                                                            : CNTW'(cfg_block_count);

   // stride: round up to the alignment, never below one pointer
   assign align_m1 = STRIDE_W'((STRIDE_W'(1) << cfg_align_log2) - STRIDE_W'(1));
   assign rounded  = (STRIDE_W'(cfg_block_bytes) + align_m1) & ~align_m1;
   assign stride   = (rounded < PTR_BYTES) ? PTR_BYTES : rounded;

   assign use_inc = (in_use_ff != USE_MAX) ? in_use_ff + USE_W'(1) : in_use_ff;

   // link memory: read the head's link at accept, write on a good free
   always_ff @(posedge clock) begin
      if (cmd.accept) link_rd_ff <= link_mem[head_ff[IW-1:0]];
      if (link_we) link_mem[IW'(index_ff)] <= head_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff    <= req_kind;
         present_ff <= req_block_present;
         index_ff   <= req_block_index;
      end
   end

   always_comb begin
      head_in   = head_ff;
      fresh_in  = fresh_ff;
      in_use_in = in_use_ff;
      peak_in   = peak_ff;
      alloc_in  = alloc_ff;
      fail_in   = fail_ff;
      status_in = STAT_OK;
      grant_in  = 1'b0;
      gidx_in   = '0;
      link_we   = 1'b0;
      case (kind_ff)
         KIND_ALLOC: begin
            if (head_ff != EMPTY) begin
               gidx_in  = head_ff[IW-1:0];
               head_in  = link_rd_ff;
               grant_in = 1'b1;
            end else if (fresh_ff < count_now) begin
               gidx_in  = IW'(fresh_ff);
               fresh_in = fresh_ff + CNTW'(1);
               grant_in = 1'b1;
            end else begin
               status_in = STAT_EXHAUSTED;
               if (fail_ff != COUNT_MAX) fail_in = fail_ff + COUNT_W'(1);
            end
            if (grant_in) begin
               in_use_in = use_inc;
               if (use_inc > peak_ff) peak_in = use_inc;
               if (alloc_ff != COUNT_MAX) alloc_in = alloc_ff + COUNT_W'(1);
            end
         end
         KIND_FREE: begin
            if (!present_ff) begin
               status_in = STAT_NULL_FREE;
            end else if (CNTW'(index_ff) >= count_now) begin
               status_in = STAT_BAD_INDEX;
            end else if (in_use_ff == '0) begin
               status_in = STAT_NONE_IN_USE;
            end else begin
               link_we   = cmd.exec;
               head_in   = HW'(index_ff);
               in_use_in = in_use_ff - USE_W'(1);
            end
         end
         KIND_REINIT: begin
            head_in   = EMPTY;
            fresh_in  = '0;
            in_use_in = '0;
            peak_in   = '0;
            alloc_in  = '0;
            fail_in   = '0;
         end
         default: status_in = STAT_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= EMPTY;
         fresh_ff  <= '0;
         in_use_ff <= '0;
         peak_ff   <= '0;
         alloc_ff  <= '0;
         fail_ff   <= '0;
      end else if (cmd.exec) begin
         head_ff   <= head_in;
         fresh_ff  <= fresh_in;
         in_use_ff <= in_use_in;
         peak_ff   <= peak_in;
         alloc_ff  <= alloc_in;
         fail_ff   <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         grant_ff  <= grant_in;
         gidx_ff   <= gidx_in;
      end
   end

   assign addr_prod = gidx_ff * stride;

   // byte counts stay below 2^28, so no saturation is needed
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         addr_prod_ff <= 32'(addr_prod);
         used_prod_ff <= in_use_ff * stride;
         peak_prod_ff <= peak_ff * stride;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status          <= status_ff;
         rsp_granted_index   <= grant_ff ? REQ_INDEX_W'(gidx_ff) : '0;
         rsp_granted_address <= grant_ff ? ((cfg_base_address + addr_prod_ff) & ADDR_MASK)
                                         : '0;
         rsp_used_bytes      <= 32'(used_prod_ff);
         rsp_peak_bytes      <= 32'(peak_prod_ff);
         rsp_alloc_total     <= alloc_ff;
         rsp_fail_total      <= fail_ff;
      end
   end

   a_peak_covers_use: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= in_use_ff)
      else $error("peak below current use");

   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= EMPTY)
      else $error("free list head out of range");

   a_fresh_in_range: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= CNT_LIMIT)
      else $error("fresh block pointer beyond pool");

endmodule

FILE: sv/fixed_block_pool_allocator_unit.sv
// Fixed-size block pool allocator.
// Requests arrive on the req_ stream: tuser carries the kind (alloc, free,
// reinit), tdata the present flag and the block index of a free. Every
// request yields exactly one transfer on the rsp_ stream with the status in
// tuser and the granted block, its address, used and peak bytes and the
// allocation and failure counters in tdata.
// The user must set the pool up over the csr_ port (base address, block count, block
// bytes, alignment) while no request is in flight; the block does not enforce it.
// A request passes the steps accept, execute against the free list (the
// head's link is read from the link memory at accept), multiply by the
// stride, then load the output register. A new request is taken only once
// the previous one has loaded its result and the block is idle again.
// The output register lets req_ take the next request while a result waits;
// a stalled receiver holds the block in its final step until rsp_tready.
// Reset empties the free list and clears use and counters; the link memory
// needs no clearing since only entries written by a free are followed.
module fixed_block_pool_allocator_unit
   import fbpa_pkg::*;
#(
   parameter int MAX_BLOCKS    = 1024,
   parameter int ADDR_BITS     = 32,
   parameter int POINTER_BYTES = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // block_present, block_index
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // granted_index, granted_address, used_bytes, peak_bytes, alloc_total, fail_total
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser,   // status
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [BASE_W-1:0]      base_address_ff;
   logic [BLK_COUNT_W-1:0] block_count_ff;
   logic [BLK_BYTES_W-1:0] block_bytes_ff;
   logic [ALIGN_W-1:0]     align_log2_ff;
   logic                   csr_write;

   cmd_type                cmd;
   logic [STATUS_W-1:0]    status;
   logic [REQ_INDEX_W-1:0] granted_index;
   logic [31:0]            granted_address;
   logic [31:0]            used_bytes;
   logic [31:0]            peak_bytes;
   logic [COUNT_W-1:0]     alloc_total;
   logic [COUNT_W-1:0]     fail_total;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= '0;
         block_count_ff  <= '0;
         block_bytes_ff  <= '0;
         align_log2_ff   <= '0;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            CSR_BASE_ADDRESS: base_address_ff <= csr_pwdata;
            CSR_BLOCK_COUNT:  block_count_ff  <= csr_pwdata[BLK_COUNT_W-1:0];
            CSR_BLOCK_BYTES:  block_bytes_ff  <= csr_pwdata[BLK_BYTES_W-1:0];
            CSR_ALIGN_LOG2:   align_log2_ff   <= csr_pwdata[ALIGN_W-1:0];
            default:          base_address_ff <= base_address_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_BASE_ADDRESS: csr_prdata = base_address_ff;
         CSR_BLOCK_COUNT:  csr_prdata = CSR_DATA_W'(block_count_ff);
         CSR_BLOCK_BYTES:  csr_prdata = CSR_DATA_W'(block_bytes_ff);
         CSR_ALIGN_LOG2:   csr_prdata = CSR_DATA_W'(align_log2_ff);
         default:          csr_prdata = '0;
      endcase
   end

   fbpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   fbpa_datapath #(
      .MAX_BLOCKS    (MAX_BLOCKS),
      .ADDR_BITS     (ADDR_BITS),
      .POINTER_BYTES (POINTER_BYTES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_kind            (req_tuser),
      .req_block_present   (req_tdata[0]),
      .req_block_index     (req_tdata[REQ_INDEX_W:1]),
      .cfg_base_address    (base_address_ff),
      .cfg_block_count     (block_count_ff),
      .cfg_block_bytes     (block_bytes_ff),
      .cfg_align_log2      (align_log2_ff),
      .rsp_status          (status),
      .rsp_granted_index   (granted_index),
      .rsp_granted_address (granted_address),
      .rsp_used_bytes      (used_bytes),
      .rsp_peak_bytes      (peak_bytes),
      .rsp_alloc_total     (alloc_total),
      .rsp_fail_total      (fail_total)
   );

   assign rsp_tuser = status;
   assign rsp_tdata = {6'd0, fail_total, alloc_total, peak_bytes, used_bytes,
                       granted_address, granted_index};

endmodule
